// ----- sv/fdes_pkg.sv -----
// types, constants and checksum helper shared by the directory entry scanner
package fdes_pkg;

  typedef enum logic [2:0] {
    KIND_END     = 3'd0,
    KIND_DELETED = 3'd1,
    KIND_PIECE   = 3'd2,
    KIND_VOLUME  = 3'd3,
    KIND_SHORT   = 3'd4
  } entry_kind_e;

  localparam logic [7:0] MARK_END       = 8'h00;
  localparam logic [7:0] MARK_DELETED   = 8'hE5;
  localparam logic [7:0] ATTR_LONG      = 8'h0F;
  localparam int unsigned ATTR_VOLUME_BIT = 3;
  localparam int unsigned ATTR_DIR_BIT    = 4;
  localparam int unsigned ORDER_LAST_BIT  = 6;
  localparam logic [5:0] COUNT_MAX      = 6'd63;

  // classified entry after the front stage register, name checksum half done
  typedef struct packed {
    logic        start;
    entry_kind_e kind;
    logic [5:0]  order;
    logic        last_piece;
    logic [7:0]  lfn_checksum;
    logic [7:0]  part_sum;
    logic [39:0] tail_bytes;
    logic        is_dir;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
  } stage_t;

  // queue entry between front and back
  typedef struct packed {
    logic        start;
    entry_kind_e kind;
    logic [5:0]  order;
    logic        last_piece;
    logic [7:0]  lfn_checksum;
    logic [7:0]  name_sum;
    logic        is_dir;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
  } item_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // one rotate-right-and-add step of the short name checksum
  function automatic logic [7:0] cks_step(input logic [7:0] sum, input logic [7:0] b);
    cks_step = {sum[0], sum[7:1]} + b;
  endfunction

endpackage

// ----- sv/fdes_if.sv -----
// handshake interfaces for directory entry beats and result beats
interface fdes_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_directory;
  logic [63:0] entry_word0;
  logic [63:0] entry_word1;
  logic [63:0] entry_word2;
  logic [63:0] entry_word3;

  modport source (output valid, output start_of_directory, output entry_word0,
                  output entry_word1, output entry_word2, output entry_word3,
                  input ready);
  modport sink (input valid, input start_of_directory, input entry_word0,
                input entry_word1, input entry_word2, input entry_word3,
                output ready);
endinterface

interface fdes_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  entry_kind;
  logic [5:0]  piece_sequence;
  logic        long_name_linked;
  logic [5:0]  piece_count;
  logic [7:0]  short_checksum;
  logic        is_directory;
  logic [31:0] first_cluster;
  logic [31:0] file_size;

  modport source (output valid, output entry_kind, output piece_sequence,
                  output long_name_linked, output piece_count, output short_checksum,
                  output is_directory, output first_cluster, output file_size,
                  input ready);
  modport sink (input valid, input entry_kind, input piece_sequence,
                input long_name_linked, input piece_count, input short_checksum,
                input is_directory, input first_cluster, input file_size,
                output ready);
endinterface

// ----- sv/fdes_front.sv -----
// front end: accepts entry beats, classifies them and computes the name checksum
module fdes_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  fdes_in_if.sink                   entry_i,
  input  fdes_pkg::queue_stat_t     q_stat_i,
  output logic                      push_o,
  output fdes_pkg::item_t           push_item_o
);

  logic             stage_v_q, stage_v_d;
  fdes_pkg::stage_t stage_q, stage_d;
  logic             accept;
  logic [7:0]       b0, attr;
  logic [7:0]       sum_a;
  logic [7:0]       sum_b;

  assign push_o        = stage_v_q && !q_stat_i.full;
  assign entry_i.ready = !stage_v_q || !q_stat_i.full;
  assign accept        = entry_i.valid && entry_i.ready;

  assign b0   = entry_i.entry_word0[7:0];
  assign attr = entry_i.entry_word1[31:24];

  // first six name bytes of the checksum
  always_comb begin
    sum_a = 8'd0;
    for (int k = 0; k < 6; k++) begin
      sum_a = fdes_pkg::cks_step(sum_a, entry_i.entry_word0[8*k +: 8]);
    end
  end

  // classification and field extraction
  always_comb begin
    stage_d.start = entry_i.start_of_directory;
    if (b0 == fdes_pkg::MARK_END) begin
      stage_d.kind = fdes_pkg::KIND_END;
    end else if (b0 == fdes_pkg::MARK_DELETED) begin
      stage_d.kind = fdes_pkg::KIND_DELETED;
    end else if (attr == fdes_pkg::ATTR_LONG) begin
      stage_d.kind = fdes_pkg::KIND_PIECE;
    end else if (attr[fdes_pkg::ATTR_VOLUME_BIT]) begin
      stage_d.kind = fdes_pkg::KIND_VOLUME;
    end else begin
      stage_d.kind = fdes_pkg::KIND_SHORT;
    end
    stage_d.order         = b0[5:0];
    stage_d.last_piece    = b0[fdes_pkg::ORDER_LAST_BIT];
    stage_d.lfn_checksum  = entry_i.entry_word1[47:40];
    stage_d.part_sum      = sum_a;
    stage_d.tail_bytes    = {entry_i.entry_word1[23:0], entry_i.entry_word0[63:48]};
    stage_d.is_dir        = attr[fdes_pkg::ATTR_DIR_BIT];
    stage_d.first_cluster = {entry_i.entry_word2[47:32], entry_i.entry_word3[31:16]};
    stage_d.file_size     = entry_i.entry_word3[63:32];
  end

  assign stage_v_d = accept || (stage_v_q && !push_o);

  // stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_v_q <= 1'b0;
    end else begin
      stage_v_q <= stage_v_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stage_q <= stage_d;
    end
  end

  // last five name bytes of the checksum
  always_comb begin
    sum_b = stage_q.part_sum;
    for (int k = 0; k < 5; k++) begin
      sum_b = fdes_pkg::cks_step(sum_b, stage_q.tail_bytes[8*k +: 8]);
    end
  end

  always_comb begin
    push_item_o.start         = stage_q.start;
    push_item_o.kind          = stage_q.kind;
    push_item_o.order         = stage_q.order;
    push_item_o.last_piece    = stage_q.last_piece;
    push_item_o.lfn_checksum  = stage_q.lfn_checksum;
    push_item_o.name_sum      = sum_b;
    push_item_o.is_dir        = stage_q.is_dir;
    push_item_o.first_cluster = stage_q.first_cluster;
    push_item_o.file_size     = stage_q.file_size;
  end

endmodule

// ----- sv/fdes_queue.sv -----
// short queue of classified entries between front and back
module fdes_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  fdes_pkg::item_t       push_item_i,
  input  logic                  pop_i,
  output fdes_pkg::item_t       head_o,
  output fdes_pkg::queue_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  fdes_pkg::item_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ----- sv/fdes_back.sv -----
// back end: applies long-name state per entry and registers the result beat
module fdes_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fdes_pkg::item_t       head_i,
  input  fdes_pkg::queue_stat_t q_stat_i,
  output logic                  pop_o,
  fdes_out_if.source            result_o
);

  typedef struct packed {
    fdes_pkg::entry_kind_e kind;
    logic [5:0]            piece_sequence;
    logic                  long_name_linked;
    logic [5:0]            piece_count;
    logic [7:0]            short_checksum;
    logic                  is_directory;
    logic [31:0]           first_cluster;
    logic [31:0]           file_size;
  } result_t;

  logic       out_v_q, out_v_d;
  result_t    res_q, res_d;
  logic [7:0] latched_q, latched_d;
  logic [5:0] pending_q, pending_d;
  logic       ended_q, ended_d;
  logic [7:0] latched_eff;
  logic [5:0] pending_eff;
  logic [5:0] count_base;
  logic       ended_eff;

  assign pop_o = !q_stat_i.empty && (!out_v_q || result_o.ready);

  // start of directory clears running state before the entry is applied
  assign latched_eff = head_i.start ? 8'd0 : latched_q;
  assign pending_eff = head_i.start ? 6'd0 : pending_q;
  assign ended_eff   = head_i.start ? 1'b0 : ended_q;
  assign count_base  = head_i.last_piece ? 6'd0 : pending_eff;

  // result and next state for the head entry
  always_comb begin
    res_d     = '0;
    res_d.kind = fdes_pkg::KIND_END;
    latched_d = latched_eff;
    pending_d = pending_eff;
    ended_d   = ended_eff;
    if (!ended_eff) begin
      res_d.kind = head_i.kind;
      case (head_i.kind)
        fdes_pkg::KIND_END: begin
          ended_d = 1'b1;
        end
        fdes_pkg::KIND_DELETED, fdes_pkg::KIND_VOLUME: begin
          pending_d = 6'd0;
        end
        fdes_pkg::KIND_PIECE: begin
          res_d.piece_sequence = head_i.order;
          if (head_i.last_piece) begin
            latched_d = head_i.lfn_checksum;
          end
          pending_d = (count_base == fdes_pkg::COUNT_MAX) ? count_base
                                                           : count_base + 6'd1;
        end
        fdes_pkg::KIND_SHORT: begin
          res_d.long_name_linked = (pending_eff != 6'd0) &&
                                   (latched_eff == head_i.name_sum);
          res_d.piece_count      = pending_eff;
          res_d.short_checksum   = head_i.name_sum;
          res_d.is_directory     = head_i.is_dir;
          res_d.first_cluster    = head_i.first_cluster;
          res_d.file_size        = head_i.file_size;
          pending_d              = 6'd0;
        end
        default: begin
          res_d.kind = fdes_pkg::KIND_END;
        end
      endcase
    end
  end

  assign out_v_d = pop_o || (out_v_q && !result_o.ready);

  // running state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      latched_q <= 8'd0;
      pending_q <= 6'd0;
      ended_q   <= 1'b0;
    end else begin
      out_v_q <= out_v_d;
      if (pop_o) begin
        latched_q <= latched_d;
        pending_q <= pending_d;
        ended_q   <= ended_d;
      end
    end
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid            = out_v_q;
  assign result_o.entry_kind       = res_q.kind;
  assign result_o.piece_sequence   = res_q.piece_sequence;
  assign result_o.long_name_linked = res_q.long_name_linked;
  assign result_o.piece_count      = res_q.piece_count;
  assign result_o.short_checksum   = res_q.short_checksum;
  assign result_o.is_directory     = res_q.is_directory;
  assign result_o.first_cluster    = res_q.first_cluster;
  assign result_o.file_size        = res_q.file_size;

endmodule

// ----- sv/fat_directory_entry_scanner_core.sv -----
// top level of the directory entry scanner: front, queue and back joined
// an accepted entry beat passes the front stage register, a queue slot and the output register
// throughput: one entry per cycle while the result side accepts beats, set by the running-state update in the back end
// the queue absorbs up to QueueDepth entries while the result side stalls
// reset clears valid flags, queue pointers, latched checksum, piece count and end flag
module fat_directory_entry_scanner_core #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdes_in_if.sink    entry_i,
  fdes_out_if.source result_o
);

  fdes_pkg::queue_stat_t q_stat;
  fdes_pkg::item_t       push_item;
  fdes_pkg::item_t       head;
  logic                  push;
  logic                  pop;

  fdes_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (entry_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_item_o (push_item)
  );

  fdes_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  fdes_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .result_o (result_o)
  );

  // queue can never be full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // short-entry fields of non-short results stay zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.entry_kind != fdes_pkg::KIND_SHORT) |->
      (result_o.first_cluster == 32'd0 && result_o.file_size == 32'd0 &&
       result_o.short_checksum == 8'd0 && result_o.piece_count == 6'd0 &&
       !result_o.long_name_linked && !result_o.is_directory))
    else $error("short entry fields set on a non-short result");

  // a linked long name needs pending pieces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.long_name_linked) |-> (result_o.piece_count != 6'd0))
    else $error("long name linked without pending pieces");

  // a popped entry always lands in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> result_o.valid)
    else $error("popped entry lost before the output register");

endmodule

// ----- sim/fat_directory_entry_scanner_core_tb.sv -----
// self-checking testbench for the directory entry scanner: directed rows, then random entries
module fat_directory_entry_scanner_core_tb;

  localparam int unsigned ITEM_TARGET    = 1450;
  localparam int unsigned STALL_LIMIT    = 1000;
  localparam int unsigned SQUEEZE_CYCLES = 150;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned BYTE_ATTR      = 11;
  localparam int unsigned BYTE_LFN_CKS   = 13;

  // one result beat as the scanner should produce it
  typedef struct packed {
    fdes_pkg::entry_kind_e kind;
    logic [5:0]            seq;
    logic                  linked;
    logic [5:0]            count;
    logic [7:0]            sum;
    logic                  dir;
    logic [31:0]           cluster;
    logic [31:0]           size;
  } scan_result_t;

  // directed stimulus row, the entry repeated reps times
  typedef struct packed {
    logic         sod;
    logic [255:0] ent;
    logic [7:0]   reps;
    logic         typed;
    scan_result_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fdes_in_if  in_bus ();
  fdes_out_if out_bus ();

  fat_directory_entry_scanner_core dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .entry_i  (in_bus),
    .result_o (out_bus)
  );

  // running state of the scanner model
  logic [7:0] lfn_cks_q;
  logic [5:0] lfn_pieces_q;
  logic       dir_ended_q;

  scan_result_t scans_due[$];
  dir_row_t     dir_rows[$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned live_items;
  int unsigned ignored_items;
  int unsigned n_short;
  int unsigned n_linked;
  int unsigned n_pieces;
  int unsigned n_saturated;
  int unsigned n_in_stalls;
  int unsigned quiet_in_left;
  int unsigned idle_cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // rotate-right-and-add over the 11 short name bytes
  function automatic logic [7:0] name_sum(input logic [255:0] e);
    logic [7:0] s;
    s = 8'h00;
    for (int k = 0; k < 11; k++) s = {s[0], s[7:1]} + e[8*k +: 8];
    return s;
  endfunction

  // classify one entry and advance the running state
  function automatic scan_result_t scan_entry(input logic sod, input logic [255:0] e);
    scan_result_t r;
    logic [7:0]   b0;
    logic [7:0]   attr;
    logic [7:0]   s;
    r = '0;
    r.kind = fdes_pkg::KIND_END;
    b0 = e[7:0];
    attr = e[8*BYTE_ATTR +: 8];
    if (sod) begin
      lfn_cks_q = 8'h00;
      lfn_pieces_q = 6'd0;
      dir_ended_q = 1'b0;
    end
    if (dir_ended_q) return r;
    if (b0 == fdes_pkg::MARK_END) begin
      dir_ended_q = 1'b1;
      return r;
    end
    if (b0 == fdes_pkg::MARK_DELETED) begin
      lfn_pieces_q = 6'd0;
      r.kind = fdes_pkg::KIND_DELETED;
      return r;
    end
    if (attr == fdes_pkg::ATTR_LONG) begin
      if (b0[fdes_pkg::ORDER_LAST_BIT]) begin
        lfn_cks_q = e[8*BYTE_LFN_CKS +: 8];
        lfn_pieces_q = 6'd0;
      end
      if (lfn_pieces_q != fdes_pkg::COUNT_MAX) lfn_pieces_q = lfn_pieces_q + 6'd1;
      r.kind = fdes_pkg::KIND_PIECE;
      r.seq = b0[5:0];
      return r;
    end
    if (attr[fdes_pkg::ATTR_VOLUME_BIT]) begin
      lfn_pieces_q = 6'd0;
      r.kind = fdes_pkg::KIND_VOLUME;
      return r;
    end
    // short entry
    s = name_sum(e);
    r.kind = fdes_pkg::KIND_SHORT;
    r.linked = (lfn_pieces_q != 6'd0) && (lfn_cks_q == s);
    r.count = lfn_pieces_q;
    r.sum = s;
    r.dir = attr[fdes_pkg::ATTR_DIR_BIT];
    r.cluster = {e[175:160], e[223:208]};
    r.size = e[255:224];
    lfn_pieces_q = 6'd0;
    return r;
  endfunction

  function automatic scan_result_t plain_result(input fdes_pkg::entry_kind_e kind,
                                                input logic [5:0] seq);
    scan_result_t r;
    r = '0;
    r.kind = kind;
    r.seq = seq;
    return r;
  endfunction

  function automatic logic [255:0] with_byte(input logic [255:0] e, input int unsigned k,
                                            input logic [7:0] v);
    e[8*k +: 8] = v;
    return e;
  endfunction

  function automatic logic [255:0] rand_entry();
    logic [255:0] e;
    for (int i = 0; i < 8; i++) e[32*i +: 32] = $urandom;
    return e;
  endfunction

  // random first byte that is neither an end marker nor a deleted mark
  function automatic logic [255:0] live_entry();
    logic [255:0] e;
    e = rand_entry();
    if (e[7:0] == fdes_pkg::MARK_END || e[7:0] == fdes_pkg::MARK_DELETED) e[7:0] = 8'h41;
    return e;
  endfunction

  function automatic logic [255:0] mk_short();
    logic [255:0] e;
    e = live_entry();
    e[8*BYTE_ATTR + fdes_pkg::ATTR_VOLUME_BIT] = 1'b0;
    return e;
  endfunction

  function automatic logic [255:0] mk_piece(input logic [7:0] ord, input logic [7:0] cks);
    logic [255:0] e;
    e = with_byte(rand_entry(), 0, ord);
    e = with_byte(e, BYTE_ATTR, fdes_pkg::ATTR_LONG);
    return with_byte(e, BYTE_LFN_CKS, cks);
  endfunction

  function automatic logic [255:0] mk_volume();
    logic [255:0] e;
    e = live_entry();
    e[8*BYTE_ATTR + fdes_pkg::ATTR_VOLUME_BIT] = 1'b1;
    return e;
  endfunction

  // mostly short gaps, a few long ones, none during a quiet stretch
  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // offer one entry beat, record its expected result once accepted
  task automatic offer(input logic sod, input logic [255:0] ent, input logic typed,
                       input scan_result_t want);
    int unsigned  gap;
    scan_result_t pred;
    if (quiet_in_left != 0) quiet_in_left--;
    else if ($urandom_range(0, 199) == 0) quiet_in_left = $urandom_range(30, 80);
    gap = pick_gap(quiet_in_left != 0);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.start_of_directory <= sod;
    in_bus.entry_word0 <= ent[63:0];
    in_bus.entry_word1 <= ent[127:64];
    in_bus.entry_word2 <= ent[191:128];
    in_bus.entry_word3 <= ent[255:192];
    do @(posedge clk); while (!in_bus.ready);
    if (dir_ended_q && !sod) ignored_items++;
    else live_items++;
    pred = scan_entry(sod, ent);
    scans_due.insert(scans_due.size(), typed ? want : pred);
    if (pred.kind == fdes_pkg::KIND_PIECE) n_pieces++;
    if (pred.kind == fdes_pkg::KIND_SHORT) n_short++;
    if (pred.linked) n_linked++;
    if (pred.count == fdes_pkg::COUNT_MAX) n_saturated++;
  endtask

  task automatic offer_live(input logic sod, input logic [255:0] ent);
    offer(sod, ent, 1'b0, '0);
  endtask

  task automatic add_row(input logic sod, input logic [255:0] ent, input logic [7:0] reps,
                         input logic typed, input scan_result_t want);
    dir_row_t row;
    row.sod = sod;
    row.ent = ent;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // long name of n pieces followed by its short entry, sometimes broken
  task automatic send_long_name(input logic sod);
    logic [255:0] sh;
    logic [7:0]   cks;
    logic [7:0]   ord;
    int unsigned  n;
    int unsigned  r;
    int unsigned  cut;
    sh = mk_short();
    cks = name_sum(sh);
    if ($urandom_range(0, 9) == 0) cks = cks ^ 8'($urandom_range(1, 255));
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 4);
    else if (r < 97) n = $urandom_range(5, 20);
    else n = $urandom_range(60, 70);
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, n) : 0;
    for (int i = n; i >= 1; i--) begin
      ord = {2'b00, 6'(i)};
      if (i == n) ord[fdes_pkg::ORDER_LAST_BIT] = 1'b1;
      if ($urandom_range(0, 3) == 0) ord[7] = 1'b1;
      if (ord == fdes_pkg::MARK_END) ord = 8'h80;
      if (ord == fdes_pkg::MARK_DELETED) ord = 8'h65;
      offer_live(sod && (i == n), mk_piece(ord, cks));
      // broken sequence: something else lands inside the long name
      if (i == cut) begin
        case ($urandom_range(0, 2))
          0: offer_live(1'b0, with_byte(rand_entry(), 0, fdes_pkg::MARK_DELETED));
          1: offer_live(1'b0, mk_volume());
          default: offer_live(1'b0, mk_piece(8'h41, 8'($urandom_range(0, 255))));
        endcase
      end
    end
    offer_live(1'b0, sh);
  endtask

  // reset and directed rows, then the random part
  initial begin
    logic [255:0] zeros;
    logic [255:0] ones;
    logic [255:0] sh;
    logic [255:0] sh2;
    logic [7:0]   cs;
    logic [7:0]   cs2;
    logic         sod_next;
    int unsigned  r;
    errors = 0;
    live_items = 0;
    ignored_items = 0;
    n_short = 0;
    n_linked = 0;
    n_pieces = 0;
    n_saturated = 0;
    quiet_in_left = 0;
    lfn_cks_q = 8'h00;
    lfn_pieces_q = 6'd0;
    dir_ended_q = 1'b0;
    rst_n = 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.start_of_directory <= 1'b0;
    in_bus.entry_word0 <= '0;
    in_bus.entry_word1 <= '0;
    in_bus.entry_word2 <= '0;
    in_bus.entry_word3 <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    zeros = '0;
    ones = '1;
    sh = mk_short();
    cs = name_sum(sh);
    sh2 = mk_short();
    cs2 = name_sum(sh2);
    // extremes and special cases, typed where the answer is obvious
    add_row(1'b1, zeros, 8'd1, 1'b1, plain_result(fdes_pkg::KIND_END, 6'd0));
    add_row(1'b0, ones, 8'd1, 1'b1, plain_result(fdes_pkg::KIND_END, 6'd0));
    add_row(1'b1, with_byte(with_byte(ones, 0, fdes_pkg::MARK_DELETED), BYTE_ATTR,
                            fdes_pkg::ATTR_LONG), 8'd1, 1'b1,
            plain_result(fdes_pkg::KIND_DELETED, 6'd0));
    add_row(1'b0, with_byte(with_byte(zeros, 0, 8'h01), BYTE_ATTR, 8'h08), 8'd1, 1'b1,
            plain_result(fdes_pkg::KIND_VOLUME, 6'd0));
    add_row(1'b0, ones, 8'd1, 1'b1, plain_result(fdes_pkg::KIND_VOLUME, 6'd0));
    add_row(1'b0, with_byte(ones, BYTE_ATTR, fdes_pkg::ATTR_LONG), 8'd1, 1'b1,
            plain_result(fdes_pkg::KIND_PIECE, 6'd63));
    add_row(1'b0, with_byte(with_byte(zeros, 0, 8'h80), BYTE_ATTR, fdes_pkg::ATTR_LONG),
            8'd1, 1'b1, plain_result(fdes_pkg::KIND_PIECE, 6'd0));
    add_row(1'b0, with_byte(zeros, 0, 8'h01), 8'd1, 1'b0, '0);
    add_row(1'b0, with_byte(ones, BYTE_ATTR, 8'hF7), 8'd1, 1'b0, '0);
    // long name that belongs to its short entry
    add_row(1'b0, mk_piece(8'h42, cs), 8'd1, 1'b0, '0);
    add_row(1'b0, mk_piece(8'h01, cs), 8'd1, 1'b0, '0);
    add_row(1'b0, sh, 8'd1, 1'b0, '0);
    // checksum mismatch
    add_row(1'b0, mk_piece(8'h41, cs ^ 8'h5A), 8'd1, 1'b0, '0);
    add_row(1'b0, sh, 8'd1, 1'b0, '0);
    // deleted entry drops the pending long name
    add_row(1'b0, mk_piece(8'h41, cs), 8'd1, 1'b0, '0);
    add_row(1'b0, with_byte(rand_entry(), 0, fdes_pkg::MARK_DELETED), 8'd1, 1'b0, '0);
    add_row(1'b0, sh, 8'd1, 1'b0, '0);
    // piece count saturation
    add_row(1'b0, mk_piece(8'h7F, cs2), 8'd1, 1'b0, '0);
    add_row(1'b0, mk_piece(8'h05, cs2), 8'd70, 1'b0, '0);
    add_row(1'b0, sh2, 8'd1, 1'b0, '0);
    // start of directory clears the pending long name
    add_row(1'b0, mk_piece(8'h41, cs), 8'd1, 1'b0, '0);
    add_row(1'b1, sh, 8'd1, 1'b0, '0);
    // end marker, then a fresh directory
    add_row(1'b0, with_byte(rand_entry(), 0, fdes_pkg::MARK_END), 8'd1, 1'b1,
            plain_result(fdes_pkg::KIND_END, 6'd0));
    add_row(1'b1, sh2, 8'd1, 1'b0, '0);

    foreach (dir_rows[i]) begin
      for (int k = 0; k < dir_rows[i].reps; k++)
        offer(dir_rows[i].sod, dir_rows[i].ent, dir_rows[i].typed, dir_rows[i].want);
    end

    // random part: mostly long names with short entries, the rest noise
    sod_next = 1'b1;
    while (live_items + ignored_items < ITEM_TARGET) begin
      r = $urandom_range(0, 99);
      sod_next = sod_next || ($urandom_range(0, 49) == 0);
      if (r < 55) send_long_name(sod_next);
      else if (r < 70) offer_live(sod_next, mk_short());
      else if (r < 78) offer_live(sod_next, with_byte(rand_entry(), 0, fdes_pkg::MARK_DELETED));
      else if (r < 86) offer_live(sod_next, mk_volume());
      else if (r < 93) offer_live(sod_next, rand_entry());
      else if (r < 96) offer_live(sod_next, mk_piece(8'($urandom_range(1, 255)),
                                                     8'($urandom_range(0, 255))));
      else begin
        offer_live(sod_next, with_byte(rand_entry(), 0, fdes_pkg::MARK_END));
        repeat ($urandom_range(0, 3)) offer_live(1'b0, rand_entry());
      end
      sod_next = dir_ended_q;
    end
    in_bus.valid <= 1'b0;

    // drain
    while (scans_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d live entries (%0d ignored after end): %0d short, %0d linked, %0d pieces",
             live_items, ignored_items, n_short, n_linked, n_pieces);
    $display("saturated piece count on %0d short entries, %0d stalled entry cycles",
             n_saturated, n_in_stalls);
    if (errors == 0 && scans_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random stalls plus a long hold-off every few hundred beats
  initial begin
    int unsigned hold_left;
    int unsigned beats_out;
    int unsigned next_squeeze;
    int unsigned quiet_left;
    int unsigned g;
    hold_left = 0;
    beats_out = 0;
    next_squeeze = 150;
    quiet_left = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid && out_bus.ready) beats_out++;
      if (hold_left != 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (beats_out >= next_squeeze) begin
        next_squeeze = next_squeeze + 500;
        hold_left = SQUEEZE_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        if (quiet_left != 0) quiet_left--;
        else if ($urandom_range(0, 199) == 0) quiet_left = $urandom_range(30, 100);
        g = pick_gap(quiet_left != 0);
        if (g != 0) begin
          hold_left = g - 1;
          out_bus.ready <= 1'b0;
        end else begin
          out_bus.ready <= 1'b1;
        end
      end
    end
  end

  task automatic compare_field(input string fname, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: result %0d %s expected 0x%0h got 0x%0h",
               $time, results_seen, fname, want, got);
    end
  endtask

  // result check against the oldest expectation
  initial results_seen = 0;
  initial n_in_stalls = 0;
  always @(posedge clk) begin
    scan_result_t want;
    if (rst_n && in_bus.valid && !in_bus.ready) n_in_stalls++;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (scans_due.size() == 0) begin
        errors++;
        $display("%0t: result beat with no entry pending, kind 0x%0h", $time,
                 out_bus.entry_kind);
      end else begin
        want = scans_due.pop_front();
        compare_field("entry_kind", 32'(want.kind), 32'(out_bus.entry_kind));
        compare_field("piece_sequence", 32'(want.seq), 32'(out_bus.piece_sequence));
        compare_field("long_name_linked", 32'(want.linked), 32'(out_bus.long_name_linked));
        compare_field("piece_count", 32'(want.count), 32'(out_bus.piece_count));
        compare_field("short_checksum", 32'(want.sum), 32'(out_bus.short_checksum));
        compare_field("is_directory", 32'(want.dir), 32'(out_bus.is_directory));
        compare_field("first_cluster", want.cluster, out_bus.first_cluster);
        compare_field("file_size", want.size, out_bus.file_size);
      end
      results_seen++;
    end
  end

  // watchdog on cycles with no beat on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no beat for %0d cycles, %0d results outstanding", $time, idle_cycles,
             scans_due.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/fdes_pkg.sv
sv/fdes_if.sv
sv/fdes_front.sv
sv/fdes_queue.sv
sv/fdes_back.sv
sv/fat_directory_entry_scanner_core.sv
sim/fat_directory_entry_scanner_core_tb.sv
